>>> hw/rtl/ll1pp_pkg.sv
// shared types and codes of the ll1 predictive parse engine
package ll1pp_pkg;

   localparam int SYM_W = 7;   // {is_terminal, id}
   localparam int ID_W  = 6;

   // configuration register indexes
   localparam logic [0:0] CSR_START = 1'b0;
   localparam logic [0:0] CSR_END   = 1'b1;

   typedef enum logic [2:0] {
      ACT_TABLE  = 3'd0,
      ACT_SYMBOL = 3'd1,
      ACT_LENGTH = 3'd2,
      ACT_FOLLOW = 3'd3,
      ACT_START  = 3'd4,
      ACT_TOKEN  = 3'd5,
      ACT_SPARE6 = 3'd6,
      ACT_SPARE7 = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      STAT_ACK      = 3'd0,
      STAT_MATCHED  = 3'd1,
      STAT_ACCEPTED = 3'd2,
      STAT_MISMATCH = 3'd3,
      STAT_NO_ENTRY = 3'd4,
      STAT_OVERFLOW = 3'd5,
      STAT_STEPS    = 3'd6,
      STAT_INACTIVE = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_TOP,
      S_LOOK,
      S_ENTRY,
      S_LEN,
      S_PUSH,
      S_OUT
   } state_type;

endpackage

>>> hw/rtl/ll1pp_ram.sv
// generic single write port ram with registered read
module ll1pp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/ll1_predictive_parse_engine.sv
// ll1 predictive parse engine: memory based stack, tables and step sequencer
// load and invalid items go from idle straight to the result state; start items pass the start state first
// token: each stack look passes top, look and entry on a nonterminal (stack, table, decide),
//   top and look on a terminal, plus length per expansion and a push per symbol; out registers the result
// one item at a time; a new item is taken once the previous result is registered
// reset: clearing pass over every table, follow and length entry, no item taken
module ll1_predictive_parse_engine #(
   parameter int TERMINALS    = 64,
   parameter int NONTERMINALS = 32,
   parameter int PRODUCTIONS  = 64,
   parameter int MAX_RHS      = 8,
   parameter int STACK_DEPTH  = 64,
   parameter int MAX_STEPS    = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [5:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [4:0] req_nonterminal,
   input  logic [5:0] req_token,
   input  logic       req_entry_valid,
   input  logic [5:0] req_production,
   input  logic [2:0] req_position,
   input  logic       req_symbol_is_terminal,
   input  logic [5:0] req_symbol_id,
   input  logic [3:0] req_rhs_length,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [8:0] rsp_expansions,
   output logic [8:0] rsp_recoveries,
   output logic [6:0] rsp_stack_level
);
   import ll1pp_pkg::*;

   localparam int CELLS     = NONTERMINALS * TERMINALS;
   localparam int SYMS      = PRODUCTIONS * MAX_RHS;
   localparam int TAW       = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PW        = (PRODUCTIONS > 1) ? $clog2(PRODUCTIONS) : 1;
   localparam int SAW       = (SYMS > 1) ? $clog2(SYMS) : 1;
   localparam int AW        = $clog2(STACK_DEPTH);
   localparam int SPW       = $clog2(STACK_DEPTH + 1);
   localparam int LW        = $clog2(MAX_RHS + 1);
   localparam int KW        = (MAX_RHS > 1) ? $clog2(MAX_RHS) : 1;
   localparam int STW       = $clog2(MAX_STEPS + 1);
   localparam int CLR_DEPTH = (CELLS > PRODUCTIONS) ? CELLS : PRODUCTIONS;
   localparam int CW        = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

   state_type        state_ff, state_in;
   logic [CW-1:0]    clr_ff, clr_in;
   logic [SPW-1:0]   sp_ff, sp_in;
   logic             active_ff, active_in;
   logic [4:0]       start_ff;
   logic [5:0]       end_ff;
   logic [5:0]       tok_ff, tok_in;
   logic [8:0]       ex_ff, ex_in, rc_ff, rc_in;
   logic [STW-1:0]   steps_ff, steps_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [LW-1:0]    n_ff, n_in;
   logic [KW-1:0]    k_ff, k_in;
   logic             ok_ff, ok_in;
   status_type       res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   logic [8:0]       rsp_ex_ff, rsp_rc_ff;
   logic [6:0]       rsp_level_ff;

   // memory ports
   logic             tbl_we, fol_we, len_we, sym_we, stk_we;
   logic [TAW-1:0]   tbl_waddr, tbl_raddr;
   logic [PW:0]      tbl_wdata, tbl_rdata;
   logic             fol_wdata, fol_rdata;
   logic [PW-1:0]    len_waddr, len_raddr;
   logic [LW-1:0]    len_wdata, len_rdata;
   logic [SAW-1:0]   sym_waddr, sym_raddr;
   logic [SYM_W-1:0] sym_wdata, sym_rdata;
   logic [AW-1:0]    stk_waddr, stk_raddr;
   logic [SYM_W-1:0] stk_wdata, stk_rdata;

   logic accept, out_free, top_term, id_ok, over;
   logic [ID_W-1:0] top_id;
   int   sym_idx;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign top_term = stk_rdata[SYM_W-1];
   assign top_id   = stk_rdata[ID_W-1:0];
   assign id_ok    = (int'(top_id) < NONTERMINALS) && (int'(tok_ff) < TERMINALS);
   assign over     = (int'(sp_ff) - 1 + int'(len_rdata)) > STACK_DEPTH;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (int'(clr_ff) == CLR_DEPTH - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_START) state_in = S_START;
               else if (req_action == ACT_TOKEN && active_ff) state_in = S_TOP;
               else state_in = S_OUT;
            end
         end
         S_START: state_in = S_OUT;
         S_TOP: begin
            if (int'(steps_ff) == MAX_STEPS || sp_ff == '0 || int'(sp_ff) > STACK_DEPTH)
               state_in = S_OUT;
            else
               state_in = S_LOOK;
         end
         S_LOOK: state_in = top_term ? S_OUT : S_ENTRY;
         S_ENTRY: begin
            if (ok_ff && tbl_rdata[PW]) state_in = S_LEN;
            else if (ok_ff && fol_rdata) state_in = S_TOP;
            else state_in = S_OUT;
         end
         S_LEN: begin
            if (over) state_in = S_OUT;
            else if (len_rdata == '0) state_in = S_TOP;
            else state_in = S_PUSH;
         end
         S_PUSH: begin
            if (int'(k_ff) == int'(n_ff) - 1) state_in = S_TOP;
         end
         S_OUT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in    = clr_ff;
      sp_in     = sp_ff;
      active_in = active_ff;
      tok_in    = tok_ff;
      ex_in     = ex_ff;
      rc_in     = rc_ff;
      steps_in  = steps_ff;
      prod_in   = prod_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      ok_in     = ok_ff;
      res_in    = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      tbl_we    = 1'b0;
      tbl_waddr = TAW'(int'(req_nonterminal) * TERMINALS + int'(req_token));
      tbl_wdata = {req_entry_valid, req_entry_valid ? PW'(req_production) : PW'(0)};
      fol_we    = 1'b0;
      fol_wdata = req_entry_valid;
      len_we    = 1'b0;
      len_waddr = PW'(req_production);
      len_wdata = (int'(req_rhs_length) > MAX_RHS) ? LW'(MAX_RHS) : LW'(req_rhs_length);
      sym_we    = 1'b0;
      sym_waddr = SAW'(int'(req_production) * MAX_RHS + int'(req_position));
      sym_wdata = {req_symbol_is_terminal, req_symbol_id};
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = {1'b1, end_ff};

      stk_raddr = AW'(int'(sp_ff) - 1);
      tbl_raddr = TAW'(int'(top_id) * TERMINALS + int'(tok_ff));
      len_raddr = tbl_rdata[PW-1:0];
      sym_idx   = (state_ff == S_LEN) ? int'(len_rdata) - 1
                                      : int'(n_ff) - 2 - int'(k_ff);
      sym_raddr = SAW'(int'(prod_ff) * MAX_RHS + sym_idx);

      case (state_ff)
         S_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = TAW'(clr_ff);
            tbl_wdata = '0;
            fol_we    = 1'b1;
            fol_wdata = 1'b0;
            len_we    = int'(clr_ff) < PRODUCTIONS;
            len_waddr = PW'(clr_ff);
            len_wdata = '0;
            clr_in    = CW'(int'(clr_ff) + 1);
         end
         S_IDLE: begin
            if (accept) begin
               res_in = STAT_ACK;
               ex_in  = '0;
               rc_in  = '0;
               steps_in = '0;
               tok_in = req_token;
               case (req_action)
                  ACT_TABLE: tbl_we = (int'(req_nonterminal) < NONTERMINALS) &&
                                      (int'(req_token) < TERMINALS) &&
                                      (int'(req_production) < PRODUCTIONS);
                  ACT_SYMBOL: sym_we = (int'(req_production) < PRODUCTIONS) &&
                                       (int'(req_position) < MAX_RHS);
                  ACT_LENGTH: len_we = int'(req_production) < PRODUCTIONS;
                  ACT_FOLLOW: fol_we = (int'(req_nonterminal) < NONTERMINALS) &&
                                       (int'(req_token) < TERMINALS);
                  ACT_START: begin
                     stk_we    = 1'b1;
                     sp_in     = SPW'(2);
                     active_in = 1'b1;
                  end
                  ACT_TOKEN: begin
                     if (!active_ff) res_in = STAT_INACTIVE;
                  end
                  default: ;
               endcase
            end
         end
         S_START: begin
            stk_we    = 1'b1;
            stk_waddr = AW'(1);
            stk_wdata = {1'b0, 1'b0, start_ff};
         end
         S_TOP: begin
            if (int'(steps_ff) == MAX_STEPS) begin
               active_in = 1'b0;
               res_in    = STAT_STEPS;
            end else if (sp_ff == '0 || int'(sp_ff) > STACK_DEPTH) begin
               active_in = 1'b0;
               res_in    = STAT_INACTIVE;
            end
         end
         S_LOOK: begin
            ok_in = id_ok;
            if (top_term) begin
               if (top_id == tok_ff) begin
                  sp_in = SPW'(int'(sp_ff) - 1);
                  if (tok_ff == end_ff) begin
                     active_in = 1'b0;
                     res_in    = STAT_ACCEPTED;
                  end else begin
                     res_in = STAT_MATCHED;
                  end
               end else begin
                  res_in = STAT_MISMATCH;
               end
            end
         end
         S_ENTRY: begin
            if (ok_ff && tbl_rdata[PW]) begin
               prod_in = tbl_rdata[PW-1:0];
            end else if (ok_ff && fol_rdata) begin
               sp_in    = SPW'(int'(sp_ff) - 1);
               rc_in    = rc_ff + 9'd1;
               steps_in = STW'(int'(steps_ff) + 1);
            end else begin
               res_in = STAT_NO_ENTRY;
            end
         end
         S_LEN: begin
            n_in = len_rdata;
            k_in = '0;
            if (over) begin
               active_in = 1'b0;
               res_in    = STAT_OVERFLOW;
            end else if (len_rdata == '0) begin
               sp_in    = SPW'(int'(sp_ff) - 1);
               ex_in    = ex_ff + 9'd1;
               steps_in = STW'(int'(steps_ff) + 1);
            end
         end
         S_PUSH: begin
            // symbols come out last first, so the leftmost ends on top
            stk_we    = 1'b1;
            stk_waddr = AW'(int'(sp_ff) - 1 + int'(k_ff));
            stk_wdata = sym_rdata;
            k_in      = KW'(int'(k_ff) + 1);
            if (int'(k_ff) == int'(n_ff) - 1) begin
               sp_in    = SPW'(int'(sp_ff) - 1 + int'(n_ff));
               ex_in    = ex_ff + 9'd1;
               steps_in = STW'(int'(steps_ff) + 1);
            end
         end
         S_OUT: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         steps_ff     <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff     <= steps_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         if (csr_we && csr_index == CSR_START) start_ff <= csr_wdata[4:0];
         if (csr_we && csr_index == CSR_END)   end_ff   <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      ex_ff   <= ex_in;
      rc_ff   <= rc_in;
      prod_ff <= prod_in;
      ok_ff   <= ok_in;
      res_ff  <= res_in;
      if (state_ff == S_OUT && out_free) begin
         rsp_status_ff <= res_ff;
         rsp_ex_ff     <= ex_ff;
         rsp_rc_ff     <= rc_ff;
         rsp_level_ff  <= 7'(sp_ff);
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_expansions  = rsp_ex_ff;
   assign rsp_recoveries  = rsp_rc_ff;
   assign rsp_stack_level = rsp_level_ff;

   ll1pp_ram #(.WIDTH(PW + 1), .DEPTH(CELLS)) u_table (
      .clock(clock), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
      .raddr(tbl_raddr), .rdata(tbl_rdata)
   );

   ll1pp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_follow (
      .clock(clock), .we(fol_we), .waddr(tbl_waddr), .wdata(fol_wdata),
      .raddr(tbl_raddr), .rdata(fol_rdata)
   );

   ll1pp_ram #(.WIDTH(LW), .DEPTH(PRODUCTIONS)) u_length (
      .clock(clock), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
      .raddr(len_raddr), .rdata(len_rdata)
   );

   ll1pp_ram #(.WIDTH(SYM_W), .DEPTH(SYMS)) u_symbols (
      .clock(clock), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
      .raddr(sym_raddr), .rdata(sym_rdata)
   );

   ll1pp_ram #(.WIDTH(SYM_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

`ifndef ASSERT_OFF
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      int'(sp_ff) <= STACK_DEPTH)
      else $error("stack pointer beyond depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUSH |-> int'(k_ff) < int'(n_ff))
      else $error("push count past production length");

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      int'(steps_ff) <= MAX_STEPS)
      else $error("step counter past limit");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_action != ACT_START && req_action != ACT_TOKEN |=> state_ff == S_OUT)
      else $error("load transaction did not go to result");
`endif

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the ll1 predictive parse engine
module tb_top;
   import ll1pp_pkg::*;

   localparam int NT_N   = 32;
   localparam int T_N    = 64;
   localparam int P_N    = 64;
   localparam int RHS_N  = 8;
   localparam int DEPTH  = 64;
   localparam int STEP_N = 256;

   typedef struct {
      logic [2:0] act;
      logic [4:0] nt;
      logic [5:0] tok;
      logic       ev;
      logic [5:0] prod;
      logic [2:0] pos;
      logic       is_term;
      logic [5:0] sym;
      logic [3:0] len;
   } parse_item_type;

   typedef struct {
      status_type status;
      logic [8:0] expansions;
      logic [8:0] recoveries;
      logic [6:0] level;
   } parse_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [0:0] csr_index = '0;
   logic [5:0] csr_wdata = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_action = '0;
   logic [4:0] req_nonterminal = '0;
   logic [5:0] req_token = '0;
   logic       req_entry_valid = 1'b0;
   logic [5:0] req_production = '0;
   logic [2:0] req_position = '0;
   logic       req_symbol_is_terminal = 1'b0;
   logic [5:0] req_symbol_id = '0;
   logic [3:0] req_rhs_length = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [8:0] rsp_expansions;
   logic [8:0] rsp_recoveries;
   logic [6:0] rsp_stack_level;

   ll1_predictive_parse_engine u_top (.*);

   // parser mirror
   logic [6:0] stack_mem [DEPTH];
   int         stack_top;
   bit         parsing;
   bit         table_ok [NT_N*T_N];
   logic [5:0] table_prod [NT_N*T_N];
   logic [6:0] rhs_syms [P_N*RHS_N];
   int         rhs_len [P_N];
   bit         follow_set [NT_N*T_N];
   logic [4:0] start_sym;
   logic [5:0] end_tok;

   // generator side bookkeeping
   bit         sym_written [P_N*RHS_N];
   parse_item_type   pending_items[$];
   parse_result_type expected_results[$];
   parse_item_type   cur_item;
   int  errors = 0;
   int  accepted_items = 0;
   int  results_seen = 0;
   int  status_seen [8];
   int  send_idle = 0;
   int  recv_stall = 0;
   bit  hold_sender = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #600000000;
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic parse_result_type parse_step(parse_item_type it);
      parse_result_type r;
      int ex, rc, base, n, idx, p;
      logic [6:0] top;
      ex = 0;
      rc = 0;
      r.status = STAT_ACK;
      case (it.act)
         ACT_TABLE: begin
            table_ok[it.nt*T_N + it.tok] = it.ev;
            table_prod[it.nt*T_N + it.tok] = it.prod;
         end
         ACT_SYMBOL: rhs_syms[it.prod*RHS_N + it.pos] = {it.is_term, it.sym};
         ACT_LENGTH: rhs_len[it.prod] = (int'(it.len) > RHS_N) ? RHS_N : int'(it.len);
         ACT_FOLLOW: follow_set[it.nt*T_N + it.tok] = it.ev;
         ACT_START: begin
            stack_mem[0] = {1'b1, end_tok};
            stack_mem[1] = {2'b00, start_sym};
            stack_top = 2;
            parsing = 1'b1;
         end
         ACT_TOKEN: begin
            if (!parsing) begin
               r.status = STAT_INACTIVE;
            end else begin
               r.status = STAT_STEPS;
               for (int s = 0; s < STEP_N; s++) begin
                  if (stack_top == 0) begin
                     parsing = 1'b0;
                     r.status = STAT_INACTIVE;
                     break;
                  end
                  top = stack_mem[stack_top-1];
                  if (top[6]) begin
                     if (top[5:0] == it.tok) begin
                        stack_top--;
                        if (it.tok == end_tok) begin
                           parsing = 1'b0;
                           r.status = STAT_ACCEPTED;
                        end else begin
                           r.status = STAT_MATCHED;
                        end
                     end else begin
                        r.status = STAT_MISMATCH;
                     end
                     break;
                  end
                  idx = int'(top[5:0])*T_N + int'(it.tok);
                  if (int'(top[5:0]) < NT_N && table_ok[idx]) begin
                     p = int'(table_prod[idx]);
                     n = rhs_len[p];
                     base = stack_top - 1;
                     if (base + n > DEPTH) begin
                        parsing = 1'b0;
                        r.status = STAT_OVERFLOW;
                        break;
                     end
                     for (int k = 0; k < n; k++)
                        stack_mem[base+k] = rhs_syms[p*RHS_N + (n-1-k)];
                     stack_top = base + n;
                     ex++;
                  end else if (int'(top[5:0]) < NT_N && follow_set[idx]) begin
                     stack_top--;
                     rc++;
                  end else begin
                     r.status = STAT_NO_ENTRY;
                     break;
                  end
               end
               if (r.status == STAT_STEPS) parsing = 1'b0;
            end
         end
         default: ;
      endcase
      r.expansions = ex[8:0];
      r.recoveries = rc[8:0];
      r.level = stack_top[6:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.insert(expected_results.size(), parse_step(cur_item));
            accepted_items++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && !hold_sender &&
                $urandom_range(99) >= send_idle) begin
               cur_item = pending_items.pop_front();
               req_action <= cur_item.act;
               req_nonterminal <= cur_item.nt;
               req_token <= cur_item.tok;
               req_entry_valid <= cur_item.ev;
               req_production <= cur_item.prod;
               req_position <= cur_item.pos;
               req_symbol_is_terminal <= cur_item.is_term;
               req_symbol_id <= cur_item.sym;
               req_rhs_length <= cur_item.len;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
               results_seen);
      errors++;
   endtask

   // monitor
   always @(posedge clock) begin
      parse_result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report("unexpected transaction", 1, 0);
            end else begin
               e = expected_results.pop_front();
               if (rsp_status != e.status) report("status", rsp_status, e.status);
               if (rsp_expansions != e.expansions)
                  report("expansions", rsp_expansions, e.expansions);
               if (rsp_recoveries != e.recoveries)
                  report("recoveries", rsp_recoveries, e.recoveries);
               if (rsp_stack_level != e.level)
                  report("stack level", rsp_stack_level, e.level);
               status_seen[e.status]++;
            end
            results_seen++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // stimulus building
   task automatic enqueue(parse_item_type it);
      pending_items.insert(pending_items.size(), it);
   endtask

   function automatic parse_item_type blank_item(logic [2:0] act);
      parse_item_type it;
      it.act = act;
      it.nt = 5'($urandom);
      it.tok = 6'($urandom);
      it.ev = 1'($urandom);
      it.prod = 6'($urandom);
      it.pos = 3'($urandom);
      it.is_term = 1'($urandom);
      it.sym = 6'($urandom);
      it.len = 4'($urandom);
      return it;
   endfunction

   task automatic add_table(int nt, int tok, bit ev, int prod);
      parse_item_type it;
      it = blank_item(ACT_TABLE);
      it.nt = 5'(nt); it.tok = 6'(tok); it.ev = ev; it.prod = 6'(prod);
      enqueue(it);
   endtask

   task automatic add_follow(int nt, int tok, bit ev);
      parse_item_type it;
      it = blank_item(ACT_FOLLOW);
      it.nt = 5'(nt); it.tok = 6'(tok); it.ev = ev;
      enqueue(it);
   endtask

   task automatic add_symbol(int prod, int pos, bit term, int sym);
      parse_item_type it;
      it = blank_item(ACT_SYMBOL);
      it.prod = 6'(prod); it.pos = 3'(pos); it.is_term = term; it.sym = 6'(sym);
      sym_written[prod*RHS_N + pos] = 1'b1;
      enqueue(it);
   endtask

   // any position the length exposes gets a symbol first
   task automatic add_length(int prod, int len);
      parse_item_type it;
      int eff;
      eff = (len > RHS_N) ? RHS_N : len;
      for (int k = 0; k < eff; k++)
         if (!sym_written[prod*RHS_N + k])
            add_symbol(prod, k, 1'($urandom), int'($urandom_range(63)));
      it = blank_item(ACT_LENGTH);
      it.prod = 6'(prod); it.len = 4'(len);
      enqueue(it);
   endtask

   task automatic add_plain(logic [2:0] act, int tok);
      parse_item_type it;
      it = blank_item(act);
      it.tok = 6'(tok);
      enqueue(it);
   endtask

   task automatic add_noise();
      parse_item_type it;
      it = blank_item(3'($urandom_range(7)));
      if (it.act == ACT_LENGTH) add_length(int'(it.prod), int'(it.len));
      else if (it.act == ACT_SYMBOL)
         add_symbol(int'(it.prod), int'(it.pos), it.is_term, int'(it.sym));
      else enqueue(it);
   endtask

   task automatic directed_items();
      add_plain(ACT_TOKEN, 5);            // token with no parse running
      add_plain(ACT_SPARE6, 0);
      add_plain(ACT_SPARE7, 63);
      add_symbol(1, 0, 1'b1, 10);         // S -> a B
      add_symbol(1, 1, 1'b0, 1);
      add_length(1, 2);
      add_length(2, 0);                   // B -> epsilon
      add_table(0, 10, 1'b1, 1);
      add_table(1, 12, 1'b1, 2);
      add_follow(1, 63, 1'b1);
      add_plain(ACT_START, 0);
      add_plain(ACT_TOKEN, 10);
      add_plain(ACT_TOKEN, 20);
      add_plain(ACT_TOKEN, 63);           // follow recovery then accept
      add_plain(ACT_START, 0);
      add_plain(ACT_TOKEN, 10);
      add_plain(ACT_TOKEN, 12);           // epsilon then mismatch
      add_plain(ACT_TOKEN, 63);
      for (int k = 0; k < RHS_N; k++) add_symbol(3, k, 1'b0, 2);
      add_length(3, 15);                  // saturates, grows until overflow
      add_table(0, 30, 1'b1, 3);
      add_table(2, 30, 1'b1, 3);
      add_plain(ACT_START, 0);
      add_plain(ACT_TOKEN, 30);
      add_symbol(4, 0, 1'b0, 3);          // self loop hits the step limit
      add_length(4, 1);
      add_table(0, 31, 1'b1, 4);
      add_table(3, 31, 1'b1, 4);
      add_plain(ACT_START, 0);
      add_plain(ACT_TOKEN, 31);
      add_symbol(5, 0, 1'b0, 40);         // nonterminal id beyond the table
      add_length(5, 1);
      add_table(0, 32, 1'b1, 5);
      add_plain(ACT_START, 0);
      add_plain(ACT_TOKEN, 32);
      add_table(0, 10, 1'b0, 1);
      add_plain(ACT_START, 0);
      add_plain(ACT_TOKEN, 10);
   endtask

   // random grammar over a few symbols, then sentences with random content
   task automatic random_items(int count);
      int nts[6];
      int toks[9];
      int n_nt, n_tok, len, p, goal;
      goal = pending_items.size() + count;
      n_nt = $urandom_range(2, 6);
      n_tok = $urandom_range(3, 8);
      nts[0] = int'(start_sym);
      for (int i = 1; i < n_nt; i++) nts[i] = $urandom_range(NT_N-1);
      for (int i = 0; i < n_tok; i++) toks[i] = $urandom_range(T_N-1);
      toks[n_tok] = int'(end_tok);
      for (int i = 0; i < n_nt; i++) begin
         for (int j = 0; j <= n_tok; j++) begin
            if ($urandom_range(99) < 55) begin
               p = $urandom_range(P_N-1);
               len = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
               for (int k = 0; k < len && k < RHS_N; k++) begin
                  if ($urandom_range(99) < 60)
                     add_symbol(p, k, 1'b1, toks[$urandom_range(n_tok)]);
                  else if ($urandom_range(19) == 0)
                     add_symbol(p, k, 1'b0, $urandom_range(63));
                  else
                     add_symbol(p, k, 1'b0, nts[$urandom_range(n_nt-1)]);
               end
               add_length(p, len);
               add_table(nts[i], toks[j], 1'b1, p);
            end else if ($urandom_range(99) < 20) begin
               add_table(nts[i], toks[j], 1'b0, $urandom_range(P_N-1));
            end
            add_follow(nts[i], toks[j], $urandom_range(99) < 35);
         end
      end
      while (pending_items.size() < goal) begin
         if ($urandom_range(99) < 8) begin
            add_noise();
         end else begin
            add_plain(ACT_START, 0);
            for (int k = $urandom_range(1, 10); k > 0; k--)
               add_plain(ACT_TOKEN, ($urandom_range(9) == 0) ? $urandom_range(63)
                                                             : toks[$urandom_range(n_tok)]);
            if ($urandom_range(99) < 70) add_plain(ACT_TOKEN, int'(end_tok));
         end
      end
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [5:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_START) start_sym = value[4:0];
      else end_tok = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int half;
      stack_top = 0;
      parsing = 1'b0;
      start_sym = '0;
      end_tok = '0;
      for (int i = 0; i < NT_N*T_N; i++) begin
         table_ok[i] = 1'b0;
         table_prod[i] = '0;
         follow_set[i] = 1'b0;
      end
      for (int i = 0; i < P_N*RHS_N; i++) begin
         rhs_syms[i] = '0;
         sym_written[i] = 1'b0;
      end
      for (int i = 0; i < P_N; i++) rhs_len[i] = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_START, 6'd0);
      write_csr(CSR_END, 6'd63);
      directed_items();
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin write_csr(CSR_START, 6'd31); write_csr(CSR_END, 6'd0); end
            1: begin write_csr(CSR_START, 6'd0); write_csr(CSR_END, 6'd63); end
            default: begin
               write_csr(CSR_START, 6'($urandom_range(31)));
               write_csr(CSR_END, 6'($urandom_range(63)));
            end
         endcase
         case (ph)
            1: begin send_idle = 76; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 76; end
            3: begin send_idle = 13; recv_stall = 13; end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         random_items(320);
         if (ph == 4) begin
            // hold the sender mid-phase until the engine has answered everything
            half = accepted_items + pending_items.size() / 2;
            while (accepted_items < half) @(posedge clock);
            hold_sender = 1'b1;
            while (req_valid || expected_results.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end

      if (expected_results.size() > 0) report("missing transactions", 0,
                                              expected_results.size());
      $display("covered %0d items over 6 phases: %0d matched, %0d accepted, %0d mismatch",
               accepted_items, status_seen[STAT_MATCHED], status_seen[STAT_ACCEPTED],
               status_seen[STAT_MISMATCH]);
      $display("  %0d no entry, %0d overflow, %0d step limit, %0d inactive, %0d acks",
               status_seen[STAT_NO_ENTRY], status_seen[STAT_OVERFLOW],
               status_seen[STAT_STEPS], status_seen[STAT_INACTIVE], status_seen[STAT_ACK]);
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
